[rtl/touch_sample_filter_and_scale_macros.svh]
// Assertion macros shared by the touch filter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TOUCH_SAMPLE_FILTER_AND_SCALE_MACROS_SVH
`define TOUCH_SAMPLE_FILTER_AND_SCALE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TSFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tsfs assertion failed");

// Next-cycle implication, checked outside reset
`define TSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tsfs assertion failed");

`endif

[rtl/tsfs_pkg.sv]
// Shared types and constants for the touch sample filter and scaler.
// No dependencies; used by the interfaces, the lanes, the merge stage and the top level.
package tsfs_pkg;

	// Input sample geometry
	localparam int SAMPLES_PER_AXIS = 4;
	localparam int RAW_W            = 13;
	localparam int SUM_W            = RAW_W + $clog2(SAMPLES_PER_AXIS);

	// Screen geometry
	localparam int SCR_W = 320;
	localparam int SCR_H = 240;
	localparam int X_W   = 9;
	localparam int Y_W   = 8;

	// Width of a raw quotient before the span check
	localparam int Q_W = 10;

	// X axis: q = (avg - 265) * 320 / 3600 = (avg - 265) * 4 / 45
	localparam int X_OFFSET  = 265;
	localparam int X_NUM     = 4;
	localparam int X_DEN     = 45;
	localparam int X_SHIFT   = 21;
	localparam int X_RECIP   = X_NUM * (((1 << X_SHIFT) + X_DEN - 1) / X_DEN);
	localparam int X_RECIP_W = 18;

	// Y axis: q = (avg - 200) * 240 / 3720 = (avg - 200) * 2 / 31
	localparam int Y_OFFSET  = 200;
	localparam int Y_NUM     = 2;
	localparam int Y_DEN     = 31;
	localparam int Y_SHIFT   = 19;
	localparam int Y_RECIP   = Y_NUM * (((1 << Y_SHIFT) + Y_DEN - 1) / Y_DEN);
	localparam int Y_RECIP_W = 16;

	// Register file
	localparam int          TOL_W     = 4;
	localparam int          TOL_RESET = 2;
	localparam int          APB_AW    = 3;
	localparam int          APB_DW    = 32;
	localparam logic [APB_AW-3:0] REG_JITTER_TOLERANCE = '0;

	typedef logic [RAW_W-1:0] raw_t;
	typedef raw_t [SAMPLES_PER_AXIS-1:0] axis_samples_t;

	// Controls from the pipeline to the merge stage
	typedef struct packed {
		logic load;    // output register takes the stage-2 values
		logic commit;  // a real item leaves stage 2 this cycle
	} merge_ctl_t;

endpackage

[rtl/tsfs_in_if.sv]
// Input channel of the touch filter: raw samples and pen flags.
// Depends on tsfs_pkg.
interface tsfs_in_if;
	logic                valid;
	logic                ready;
	tsfs_pkg::raw_t      x_raw_0;
	tsfs_pkg::raw_t      x_raw_1;
	tsfs_pkg::raw_t      x_raw_2;
	tsfs_pkg::raw_t      x_raw_3;
	tsfs_pkg::raw_t      y_raw_0;
	tsfs_pkg::raw_t      y_raw_1;
	tsfs_pkg::raw_t      y_raw_2;
	tsfs_pkg::raw_t      y_raw_3;
	logic                pen_down;
	logic                pen_still_down;

	modport source (
		output valid, x_raw_0, x_raw_1, x_raw_2, x_raw_3,
		output y_raw_0, y_raw_1, y_raw_2, y_raw_3, pen_down, pen_still_down,
		input  ready
	);
	modport sink (
		input  valid, x_raw_0, x_raw_1, x_raw_2, x_raw_3,
		input  y_raw_0, y_raw_1, y_raw_2, y_raw_3, pen_down, pen_still_down,
		output ready
	);
endinterface

[rtl/tsfs_out_if.sv]
// Output channel of the touch filter: validity flag and screen coordinates.
// Depends on tsfs_pkg.
interface tsfs_out_if;
	logic                       valid;
	logic                       ready;
	logic                       touch_valid;
	logic [tsfs_pkg::X_W-1:0]   screen_x;
	logic [tsfs_pkg::Y_W-1:0]   screen_y;

	modport source (output valid, touch_valid, screen_x, screen_y, input ready);
	modport sink   (input  valid, touch_valid, screen_x, screen_y, output ready);
endinterface

[rtl/tsfs_axis_lane.sv]
// One axis lane: trimmed mean of the samples, then constant-ratio scaling.
// Depends on tsfs_pkg. Two stages; the coordinate is formed from the stage-2 registers.
module tsfs_axis_lane #(
	parameter int OFFSET  = tsfs_pkg::X_OFFSET,
	parameter int FULL    = tsfs_pkg::SCR_W,
	parameter int RECIP   = tsfs_pkg::X_RECIP,
	parameter int RECIP_W = tsfs_pkg::X_RECIP_W,
	parameter int SHIFT   = tsfs_pkg::X_SHIFT,
	parameter int COORD_W = tsfs_pkg::X_W
) (
	input  logic                          clk,
	input  tsfs_pkg::axis_samples_t       samples,
	input  logic                          en_s1,
	input  logic                          en_s2,
	output logic [COORD_W-1:0]            coord
);

	localparam int PROD_W = tsfs_pkg::RAW_W + RECIP_W;

	logic [tsfs_pkg::SUM_W-1:0] sum;
	logic [tsfs_pkg::SUM_W-1:0] mid;
	tsfs_pkg::raw_t             mx;
	tsfs_pkg::raw_t             mn;
	tsfs_pkg::raw_t             avg;

	tsfs_pkg::raw_t             diff_s1;
	logic                       above_s1;
	logic [PROD_W-1:0]          prod_s2;
	logic                       above_s2;
	logic [tsfs_pkg::Q_W-1:0]   quot;

	// Sum, largest and smallest sample; average the middle two
	always_comb begin
		sum = '0;
		mx  = '0;
		mn  = '1;
		for (int i = 0; i < tsfs_pkg::SAMPLES_PER_AXIS; i++) begin
			sum = sum + tsfs_pkg::SUM_W'(samples[i]);
			if (samples[i] > mx) mx = samples[i];
			if (samples[i] < mn) mn = samples[i];
		end
		mid = sum - tsfs_pkg::SUM_W'(mx) - tsfs_pkg::SUM_W'(mn);
		avg = mid[tsfs_pkg::RAW_W:1];
	end

	// Stage 1: remove the offset
	always_ff @(posedge clk) begin
		if (en_s1) begin
			above_s1 <= avg > tsfs_pkg::RAW_W'(OFFSET);
			diff_s1  <= avg - tsfs_pkg::RAW_W'(OFFSET);
		end
	end

	// Stage 2: multiply by the scaled reciprocal of the span ratio
	always_ff @(posedge clk) begin
		if (en_s2) begin
			above_s2 <= above_s1;
			prod_s2  <= PROD_W'(diff_s1) * PROD_W'(RECIP);
		end
	end

	// Quotient, span check and inversion
	assign quot  = prod_s2[SHIFT +: tsfs_pkg::Q_W];
	assign coord = (above_s2 && quot != '0 && quot <= tsfs_pkg::Q_W'(FULL))
		? COORD_W'(tsfs_pkg::Q_W'(FULL) - quot) : '0;

endmodule

[rtl/tsfs_merge.sv]
// Merge stage: border check, jitter compare against the last coordinates, output register.
// Depends on tsfs_pkg and the assertion macro header.
`include "touch_sample_filter_and_scale_macros.svh"

module tsfs_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsfs_pkg::merge_ctl_t          ctl,
	input  logic [tsfs_pkg::X_W-1:0]      sx,
	input  logic [tsfs_pkg::Y_W-1:0]      sy,
	input  logic                          pen_ok,
	input  logic [tsfs_pkg::TOL_W-1:0]    tol,
	output logic                          touch_valid,
	output logic [tsfs_pkg::X_W-1:0]      screen_x,
	output logic [tsfs_pkg::Y_W-1:0]      screen_y
);

	logic [tsfs_pkg::X_W-1:0] prev_x_q;
	logic [tsfs_pkg::Y_W-1:0] prev_y_q;
	logic                     touch_valid_q;
	logic [tsfs_pkg::X_W-1:0] screen_x_q;
	logic [tsfs_pkg::Y_W-1:0] screen_y_q;

	logic                     in_border;
	logic [tsfs_pkg::X_W-1:0] dx;
	logic [tsfs_pkg::Y_W-1:0] dy;
	logic                     stable;

	// Inside the border: sx from 2 to SCR_W - 2, sy from 2 to SCR_H - 2
	assign in_border = (sx > tsfs_pkg::X_W'(1))
		&& (sx < tsfs_pkg::X_W'(tsfs_pkg::SCR_W - 1))
		&& (sy > tsfs_pkg::Y_W'(1))
		&& (sy < tsfs_pkg::Y_W'(tsfs_pkg::SCR_H - 1));

	// Distance to the last in-border coordinates
	assign dx     = (sx > prev_x_q) ? sx - prev_x_q : prev_x_q - sx;
	assign dy     = (sy > prev_y_q) ? sy - prev_y_q : prev_y_q - sy;
	assign stable = (dx <= tsfs_pkg::X_W'(tol)) && (dy <= tsfs_pkg::Y_W'(tol));

	// Hold the last in-border coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (ctl.commit && in_border) begin
			prev_x_q <= sx;
			prev_y_q <= sy;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_valid_q <= 1'b0;
			screen_x_q    <= '0;
			screen_y_q    <= '0;
		end else if (ctl.load) begin
			touch_valid_q <= in_border && pen_ok && stable;
			screen_x_q    <= sx;
			screen_y_q    <= sy;
		end
	end

	assign touch_valid = touch_valid_q;
	assign screen_x    = screen_x_q;
	assign screen_y    = screen_y_q;

	`TSFS_ASSERT_NEXT(a_prev_hold, clk, arst_n, !ctl.commit,
		$stable(prev_x_q) && $stable(prev_y_q))
	`TSFS_ASSERT_NEXT(a_prev_follows, clk, arst_n, ctl.commit && in_border,
		prev_x_q == screen_x_q && prev_y_q == screen_y_q)
	`TSFS_ASSERT_NOW(a_valid_in_border, clk, arst_n, touch_valid_q,
		screen_x_q > tsfs_pkg::X_W'(1) && screen_y_q > tsfs_pkg::Y_W'(1))

endmodule

[rtl/touch_sample_filter_and_scale.sv]
// Channel      | Role   | Contents
// samples      | sink   | x_raw_0..3, y_raw_0..3 (13 b each), pen_down, pen_still_down
// result       | source | touch_valid, screen_x (9 b), screen_y (8 b)
// APB          | slave  | jitter_tolerance at byte address 0
//
// Items pass the stage-1, stage-2 and output registers; one per cycle unless result stalls.
// Stage 1 runs the trimmed mean in each axis lane, stage 2 the reciprocal multiply,
// stage 3 the merge with the stored previous coordinates and the output register.
// Each stage advances when the next one is empty or advancing, so bubbles are filled
// while a result waits. Reset clears the valid bits, tolerance (to 2) and previous coordinates.
//
// Top level: two axis lanes, the merge stage, pipeline control and the register port.
// Depends on tsfs_pkg, tsfs_in_if, tsfs_out_if, tsfs_axis_lane, tsfs_merge and the macro header.
`include "touch_sample_filter_and_scale_macros.svh"

module touch_sample_filter_and_scale (
	input  logic                             clk,
	input  logic                             arst_n,
	tsfs_in_if.sink                          samples,
	tsfs_out_if.source                       result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tsfs_pkg::APB_AW-1:0]      paddr,
	input  logic [tsfs_pkg::APB_DW-1:0]      pwdata,
	output logic [tsfs_pkg::APB_DW-1:0]      prdata,
	output logic                             pready
);

	logic                           v_s1;
	logic                           v_s2;
	logic                           out_v_q;
	logic                           pen_s1;
	logic                           pen_s2;
	logic [tsfs_pkg::TOL_W-1:0]     tol_q;

	logic                           adv1;
	logic                           adv2;
	logic                           adv_o;
	logic                           reg_hit;
	tsfs_pkg::axis_samples_t        xs;
	tsfs_pkg::axis_samples_t        ys;
	logic [tsfs_pkg::X_W-1:0]       sx;
	logic [tsfs_pkg::Y_W-1:0]       sy;
	tsfs_pkg::merge_ctl_t           mctl;

	// Register port: single register, always ready
	assign pready  = 1'b1;
	assign reg_hit = paddr[tsfs_pkg::APB_AW-1:2] == tsfs_pkg::REG_JITTER_TOLERANCE;
	assign prdata  = reg_hit ? tsfs_pkg::APB_DW'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= tsfs_pkg::TOL_W'(tsfs_pkg::TOL_RESET);
		end else if (psel && penable && pwrite && reg_hit) begin
			tol_q <= pwdata[tsfs_pkg::TOL_W-1:0];
		end
	end

	// Stage enables: advance into an empty or draining stage
	assign adv_o         = !out_v_q || result.ready;
	assign adv2          = !v_s2 || adv_o;
	assign adv1          = !v_s1 || adv2;
	assign samples.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv1)  v_s1    <= samples.valid;
			if (adv2)  v_s2    <= v_s1;
			if (adv_o) out_v_q <= v_s2;
		end
	end

	// Pen flags travel beside the lanes
	always_ff @(posedge clk) begin
		if (adv1) pen_s1 <= samples.pen_down && samples.pen_still_down;
		if (adv2) pen_s2 <= pen_s1;
	end

	assign xs = {samples.x_raw_3, samples.x_raw_2, samples.x_raw_1, samples.x_raw_0};
	assign ys = {samples.y_raw_3, samples.y_raw_2, samples.y_raw_1, samples.y_raw_0};

	tsfs_axis_lane #(
		.OFFSET  (tsfs_pkg::X_OFFSET),
		.FULL    (tsfs_pkg::SCR_W),
		.RECIP   (tsfs_pkg::X_RECIP),
		.RECIP_W (tsfs_pkg::X_RECIP_W),
		.SHIFT   (tsfs_pkg::X_SHIFT),
		.COORD_W (tsfs_pkg::X_W)
	) u_lane_x (
		.clk     (clk),
		.samples (xs),
		.en_s1   (adv1),
		.en_s2   (adv2),
		.coord   (sx)
	);

	tsfs_axis_lane #(
		.OFFSET  (tsfs_pkg::Y_OFFSET),
		.FULL    (tsfs_pkg::SCR_H),
		.RECIP   (tsfs_pkg::Y_RECIP),
		.RECIP_W (tsfs_pkg::Y_RECIP_W),
		.SHIFT   (tsfs_pkg::Y_SHIFT),
		.COORD_W (tsfs_pkg::Y_W)
	) u_lane_y (
		.clk     (clk),
		.samples (ys),
		.en_s1   (adv1),
		.en_s2   (adv2),
		.coord   (sy)
	);

	// Merge the two lanes with the stored coordinates
	assign mctl.load   = adv_o;
	assign mctl.commit = adv_o && v_s2;

	tsfs_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (mctl),
		.sx          (sx),
		.sy          (sy),
		.pen_ok      (pen_s2),
		.tol         (tol_q),
		.touch_valid (result.touch_valid),
		.screen_x    (result.screen_x),
		.screen_y    (result.screen_y)
	);

	assign result.valid = out_v_q;

	`TSFS_ASSERT_NOW(a_stall_full, clk, arst_n, !samples.ready, v_s1 && v_s2 && out_v_q && !result.ready)
	`TSFS_ASSERT_NEXT(a_accept_s1, clk, arst_n, samples.valid && samples.ready, v_s1)
	`TSFS_ASSERT_NEXT(a_drain, clk, arst_n, out_v_q && result.ready && !v_s2, !out_v_q)

endmodule
